// ===== rtl/rcwm_pkg.sv =====
// Package for the windowed RMS current meter: field widths, register reset
// values, register indexes, sequencer states and step counts.
// No dependencies; every other file refers to it by scoped names.
package rcwm_pkg;

    // Window length in samples
    localparam int WINDOW_SAMPLES = 40;

    // Field and register widths
    localparam int SAMPLE_W   = 12;
    localparam int FLOOR_W    = 11;
    localparam int GAIN_W     = 16;
    localparam int AMPS_W     = 27;
    localparam int COUNTS_W   = 20;
    localparam int COUNT_W    = 6;
    localparam int SUM_W      = 30;
    localparam int SQR_W      = 2 * SAMPLE_W;
    localparam int MEAN_FRAC  = 16;
    localparam int MEAN_W     = SUM_W + MEAN_FRAC;
    localparam int REM_W      = $clog2(WINDOW_SAMPLES + 1);
    localparam int ROOT_W     = MEAN_W / 2;
    localparam int ROOT_REM_W = ROOT_W + 3;
    localparam int EXCESS_W   = COUNTS_W;
    localparam int PROD_W     = EXCESS_W + GAIN_W;
    localparam int Q8_SHIFT   = 8;
    localparam int STEP_W     = $clog2(MEAN_W);

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Step counts of the serial units
    localparam int SQUARE_STEPS = SAMPLE_W;
    localparam int DIVIDE_STEPS = MEAN_W;
    localparam int ROOT_STEPS   = ROOT_W;
    localparam int SCALE_STEPS  = GAIN_W;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] MIDSCALE_RESET = SAMPLE_W'(2048);
    localparam logic [FLOOR_W-1:0]  FLOOR_RESET    = FLOOR_W'(8);
    localparam logic [GAIN_W-1:0]   GAIN_RESET     = GAIN_W'(1807);

    localparam logic [COUNT_W-1:0] WINDOW_COUNT = COUNT_W'(WINDOW_SAMPLES);
    localparam logic [REM_W:0]     DIVISOR      = (REM_W + 1)'(WINDOW_SAMPLES);
    localparam logic [AMPS_W-1:0]  AMPS_MAX     = {AMPS_W{1'b1}};

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MIDSCALE = 2'd0,
        REG_NOISE    = 2'd1,
        REG_GAIN     = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIVIDE,
        ST_ROOT,
        ST_FLOOR,
        ST_SCALE,
        ST_LOAD
    } state_t;

endpackage

// ===== rtl/rcwm_ifs.sv =====
// Channel interfaces of the windowed RMS current meter: sample input,
// result output and configuration write. Depends on rcwm_pkg.
interface rcwm_sample_if;
    logic                          valid;
    logic                          ready;
    logic [rcwm_pkg::SAMPLE_W-1:0] current_sample;

    modport source (output valid, output current_sample, input ready);
    modport sink   (input valid, input current_sample, output ready);
endinterface

interface rcwm_result_if;
    logic                          valid;
    logic                          ready;
    logic [rcwm_pkg::AMPS_W-1:0]   rms_amps;
    logic [rcwm_pkg::COUNTS_W-1:0] rms_counts;

    modport source (output valid, output rms_amps, output rms_counts, input ready);
    modport sink   (input valid, input rms_amps, input rms_counts, output ready);
endinterface

interface rcwm_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rcwm_pkg::CFG_INDEX_W-1:0] index;
    logic [rcwm_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/rms_current_window_meter_core.sv =====
// Windowed RMS current meter top level: serial squarer, divider by the
// window length, square root and gain multiplier around one sequencer.
// Depends on rcwm_pkg and the channel interfaces in rcwm_ifs.sv.
//
// Usage:
//   sample : one raw 12-bit current conversion per transfer.
//   result : one transfer per window of WINDOW_SAMPLES samples, carrying
//            rms_counts (Q8 counts) and rms_amps (Q16 amps after floor,
//            clamp at zero and gain, saturated).
//   cfg    : register writes, index 0 midscale offset, 1 noise floor,
//            2 gain; always ready, unknown indexes are dropped.
// Sequence: sample.ready drops after each transfer while the bit-serial
//   squarer runs and the square is accumulated, so a new sample is taken
//   only once the last one is through. The last sample of a window adds the
//   restoring division by the window length, the two-bit-per-step root,
//   a floor step, the serial gain multiply and a load step; with a free
//   output register result.valid and sample.ready rise together after it.
// Reset clears the registers to their defaults, the sum and the counter.
// A stalled result sits in the output register while samples keep coming;
// only a second finished window waits in the load step until it drains.
module rms_current_window_meter_core (
    input  logic           clk,
    input  logic           rst_n,
    rcwm_cfg_if.sink       cfg,
    rcwm_sample_if.sink    sample,
    rcwm_result_if.source  result
);

    rcwm_pkg::state_t state_reg, seq_next;

    logic [rcwm_pkg::STEP_W-1:0]   step_reg;
    logic [rcwm_pkg::COUNT_W-1:0]  count_reg;
    logic [rcwm_pkg::SUM_W-1:0]    sum_reg;
    logic                          out_valid_reg;

    logic [rcwm_pkg::SAMPLE_W-1:0] midscale_reg;
    logic [rcwm_pkg::FLOOR_W-1:0]  floor_reg;
    logic [rcwm_pkg::GAIN_W-1:0]   gain_reg;

    // Datapath payload
    logic [rcwm_pkg::SAMPLE_W-1:0]   mag_reg;
    logic [rcwm_pkg::SQR_W-1:0]      sq_reg;
    logic [rcwm_pkg::MEAN_W-1:0]     div_reg;
    logic [rcwm_pkg::REM_W-1:0]      div_rem_reg;
    logic [rcwm_pkg::ROOT_W-1:0]     root_reg;
    logic [rcwm_pkg::ROOT_REM_W-1:0] root_rem_reg;
    logic [rcwm_pkg::EXCESS_W-1:0]   excess_reg;
    logic [rcwm_pkg::PROD_W-1:0]     scale_reg;
    logic [rcwm_pkg::COUNTS_W-1:0]   counts_reg;
    logic [rcwm_pkg::AMPS_W-1:0]     amps_out_reg;
    logic [rcwm_pkg::COUNTS_W-1:0]   counts_out_reg;

    // Handshake and sequencing strobes
    logic sample_xfer;
    logic result_xfer;
    logic last_step;
    logic load_out;
    logic window_done;

    // Arithmetic of one step
    logic [rcwm_pkg::SAMPLE_W-1:0]   mag_now;
    logic [rcwm_pkg::SAMPLE_W:0]     sq_sum;
    logic [rcwm_pkg::SUM_W-1:0]      sum_new;
    logic [rcwm_pkg::REM_W:0]        div_try;
    logic                            div_ge;
    logic [rcwm_pkg::ROOT_REM_W-1:0] root_try;
    logic [rcwm_pkg::ROOT_REM_W-1:0] root_trial;
    logic                            root_ge;
    logic [rcwm_pkg::COUNTS_W-1:0]   floor_q8;
    logic [rcwm_pkg::COUNTS_W-1:0]   counts_now;
    logic [rcwm_pkg::EXCESS_W:0]     scale_sum;
    logic [rcwm_pkg::AMPS_W-1:0]     amps_sat;

    assign sample_xfer = sample.valid && sample.ready;
    assign result_xfer = result.valid && result.ready;

    // Magnitude of sample minus offset, taken at the transfer
    assign mag_now = (sample.current_sample >= midscale_reg)
                   ? (sample.current_sample - midscale_reg)
                   : (midscale_reg - sample.current_sample);

    // Shift-add squarer: add the multiplicand at the top, shift right
    assign sq_sum = {1'b0, sq_reg[rcwm_pkg::SQR_W-1:rcwm_pkg::SAMPLE_W]}
                  + (sq_reg[0] ? {1'b0, mag_reg} : '0);

    assign sum_new     = sum_reg + rcwm_pkg::SUM_W'(sq_reg);
    assign window_done = (count_reg + 1'b1) == rcwm_pkg::WINDOW_COUNT;

    // Restoring divider by the window length, one quotient bit a step
    assign div_try = {div_rem_reg, div_reg[rcwm_pkg::MEAN_W-1]};
    assign div_ge  = div_try >= rcwm_pkg::DIVISOR;

    // Restoring root, two radicand bits a step
    assign root_try   = {root_rem_reg[rcwm_pkg::ROOT_REM_W-3:0],
                         div_reg[rcwm_pkg::MEAN_W-1 -: 2]};
    assign root_trial = rcwm_pkg::ROOT_REM_W'({root_reg, 2'b01});
    assign root_ge    = root_try >= root_trial;

    // Floor subtraction in Q8 with clamp at zero
    assign counts_now = root_reg[rcwm_pkg::COUNTS_W-1:0];
    assign floor_q8   = rcwm_pkg::COUNTS_W'({floor_reg, {rcwm_pkg::Q8_SHIFT{1'b0}}});

    // Shift-add gain multiplier
    assign scale_sum = {1'b0, scale_reg[rcwm_pkg::PROD_W-1:rcwm_pkg::GAIN_W]}
                     + (scale_reg[0] ? {1'b0, excess_reg} : '0);

    // Drop the Q8 fraction and saturate
    assign amps_sat =
        (|scale_reg[rcwm_pkg::PROD_W-1:rcwm_pkg::Q8_SHIFT+rcwm_pkg::AMPS_W])
        ? rcwm_pkg::AMPS_MAX
        : scale_reg[rcwm_pkg::Q8_SHIFT+rcwm_pkg::AMPS_W-1:rcwm_pkg::Q8_SHIFT];

    // Next state
    always_comb
    begin
        seq_next = state_reg;
        unique case (state_reg)
            rcwm_pkg::ST_IDLE:
            begin
                if (sample_xfer)
                    seq_next = rcwm_pkg::ST_SQUARE;
            end
            rcwm_pkg::ST_SQUARE:
            begin
                if (last_step)
                    seq_next = rcwm_pkg::ST_ACCUM;
            end
            rcwm_pkg::ST_ACCUM:
            begin
                seq_next = window_done ? rcwm_pkg::ST_DIVIDE : rcwm_pkg::ST_IDLE;
            end
            rcwm_pkg::ST_DIVIDE:
            begin
                if (last_step)
                    seq_next = rcwm_pkg::ST_ROOT;
            end
            rcwm_pkg::ST_ROOT:
            begin
                if (last_step)
                    seq_next = rcwm_pkg::ST_FLOOR;
            end
            rcwm_pkg::ST_FLOOR:
            begin
                seq_next = rcwm_pkg::ST_SCALE;
            end
            rcwm_pkg::ST_SCALE:
            begin
                if (last_step)
                    seq_next = rcwm_pkg::ST_LOAD;
            end
            rcwm_pkg::ST_LOAD:
            begin
                if (load_out)
                    seq_next = rcwm_pkg::ST_IDLE;
            end
            default:
            begin
                seq_next = rcwm_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and strobes
    always_comb
    begin
        sample.ready = 1'b0;
        last_step    = 1'b0;
        load_out     = 1'b0;
        unique case (state_reg)
            rcwm_pkg::ST_IDLE:
                sample.ready = 1'b1;
            rcwm_pkg::ST_SQUARE:
                last_step = step_reg == rcwm_pkg::STEP_W'(rcwm_pkg::SQUARE_STEPS - 1);
            rcwm_pkg::ST_DIVIDE:
                last_step = step_reg == rcwm_pkg::STEP_W'(rcwm_pkg::DIVIDE_STEPS - 1);
            rcwm_pkg::ST_ROOT:
                last_step = step_reg == rcwm_pkg::STEP_W'(rcwm_pkg::ROOT_STEPS - 1);
            rcwm_pkg::ST_SCALE:
                last_step = step_reg == rcwm_pkg::STEP_W'(rcwm_pkg::SCALE_STEPS - 1);
            rcwm_pkg::ST_LOAD:
                load_out = !out_valid_reg || result.ready;
            default:
            begin
                sample.ready = 1'b0;
            end
        endcase
    end

    assign cfg.ready         = 1'b1;
    assign result.valid      = out_valid_reg;
    assign result.rms_amps   = amps_out_reg;
    assign result.rms_counts = counts_out_reg;

    // Control state, window accumulator and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcwm_pkg::ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            midscale_reg  <= rcwm_pkg::MIDSCALE_RESET;
            floor_reg     <= rcwm_pkg::FLOOR_RESET;
            gain_reg      <= rcwm_pkg::GAIN_RESET;
        end
        else
        begin
            state_reg <= seq_next;

            // Restart the step counter on every state change
            if (seq_next != state_reg)
                step_reg <= '0;
            else
                step_reg <= step_reg + 1'b1;

            if (state_reg == rcwm_pkg::ST_ACCUM)
            begin
                if (window_done)
                begin
                    count_reg <= '0;
                    sum_reg   <= '0;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                    sum_reg   <= sum_new;
                end
            end

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (result_xfer)
                out_valid_reg <= 1'b0;

            if (cfg.valid && cfg.ready)
            begin
                unique case (rcwm_pkg::reg_index_t'(cfg.index))
                    rcwm_pkg::REG_MIDSCALE:
                        midscale_reg <= cfg.data[rcwm_pkg::SAMPLE_W-1:0];
                    rcwm_pkg::REG_NOISE:
                        floor_reg <= cfg.data[rcwm_pkg::FLOOR_W-1:0];
                    rcwm_pkg::REG_GAIN:
                        gain_reg <= cfg.data[rcwm_pkg::GAIN_W-1:0];
                    default:
                    begin
                        // drop writes to unknown indexes
                    end
                endcase
            end
        end
    end

    // Serial datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            rcwm_pkg::ST_IDLE:
            begin
                if (sample_xfer)
                begin
                    mag_reg <= mag_now;
                    sq_reg  <= rcwm_pkg::SQR_W'(mag_now);
                end
            end
            rcwm_pkg::ST_SQUARE:
            begin
                sq_reg <= {sq_sum, sq_reg[rcwm_pkg::SAMPLE_W-1:1]};
            end
            rcwm_pkg::ST_ACCUM:
            begin
                // Hand the finished sum, in Q16, to the divider
                div_reg     <= {sum_new, {rcwm_pkg::MEAN_FRAC{1'b0}}};
                div_rem_reg <= '0;
            end
            rcwm_pkg::ST_DIVIDE:
            begin
                div_rem_reg <= div_ge ? rcwm_pkg::REM_W'(div_try - rcwm_pkg::DIVISOR)
                                      : rcwm_pkg::REM_W'(div_try);
                div_reg     <= {div_reg[rcwm_pkg::MEAN_W-2:0], div_ge};
                root_reg     <= '0;
                root_rem_reg <= '0;
            end
            rcwm_pkg::ST_ROOT:
            begin
                root_rem_reg <= root_ge ? (root_try - root_trial) : root_try;
                root_reg     <= {root_reg[rcwm_pkg::ROOT_W-2:0], root_ge};
                div_reg      <= {div_reg[rcwm_pkg::MEAN_W-3:0], 2'b00};
            end
            rcwm_pkg::ST_FLOOR:
            begin
                counts_reg <= counts_now;
                excess_reg <= (counts_now > floor_q8) ? (counts_now - floor_q8) : '0;
                scale_reg  <= rcwm_pkg::PROD_W'(gain_reg);
            end
            rcwm_pkg::ST_SCALE:
            begin
                scale_reg <= {scale_sum, scale_reg[rcwm_pkg::GAIN_W-1:1]};
            end
            rcwm_pkg::ST_LOAD:
            begin
                if (load_out)
                begin
                    amps_out_reg   <= amps_sat;
                    counts_out_reg <= counts_reg;
                end
            end
            default:
            begin
                // hold
            end
        endcase
    end

endmodule
